/* rtl/kwi_pkg.sv */
package kwi_pkg;

    // default sizes of the word table and position limits
    localparam int WORD_TABLE_DEPTH = 65536;
    localparam int MAX_REPS         = 8;
    localparam int MAX_SEQ_LEN      = 65536;

    // fixed field widths
    localparam int HIST_DEPTH = 8;
    localparam int HIST_IW    = 3;
    localparam int ALPHA_W    = 5;
    localparam int WLEN_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int LETTER_W   = 5;
    localparam int WORD_W     = 16;
    localparam int HITS_W     = 4;
    localparam int POS_OUT_W  = 16;
    localparam int COMMON_W   = 17;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 5'd4;
    localparam logic [WLEN_W-1:0]   WLEN_RESET   = 4'd8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_SIZE        = 2'd0,
        CFG_WORD_LENGTH       = 2'd1,
        CFG_HIGH_PLACE_WEIGHT = 2'd2
    } t_cfg_idx;

    // table access strobes
    typedef struct packed {
        logic rd;
        logic cnt_we;
        logic pos_we;
    } t_tbl_ctl;

endpackage

/* rtl/kmer_word_index_and_match_core.sv */
// channel   direction  ports                                             transfer
// letter    in         start, busy, i_opcode, i_letter, i_first, i_last  start && !busy
// result    out        o_valid, o_word, o_a_hits, o_a_first_pos,         o_valid, one cycle
//                      o_common_count, o_end_of_seq
// config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata                  i_cfg_we
//
// a letter that completes no word only updates the word; a completed word goes on to the
// table read and then the read-modify-write of the hit count for A or the result for B;
// the result is registered and shows in the cycle after; a first A letter adds a sweep
// over all hit-count entries, one entry a cycle; reset runs it too, busy high throughout
// one letter is in flight at a time; the receiver cannot stall the result strobe
module kmer_word_index_and_match_core #(
    parameter int WORD_TABLE_DEPTH = kwi_pkg::WORD_TABLE_DEPTH,
    parameter int MAX_REPS         = kwi_pkg::MAX_REPS,
    parameter int MAX_SEQ_LEN      = kwi_pkg::MAX_SEQ_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [kwi_pkg::LETTER_W-1:0]   i_letter,
    input  logic                           i_first,
    input  logic                           i_last,
    input  logic                           i_cfg_we,
    input  logic [kwi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kwi_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_valid,
    output logic [kwi_pkg::WORD_W-1:0]     o_word,
    output logic [kwi_pkg::HITS_W-1:0]     o_a_hits,
    output logic [kwi_pkg::POS_OUT_W-1:0]  o_a_first_pos,
    output logic [kwi_pkg::COMMON_W-1:0]   o_common_count,
    output logic                           o_end_of_seq
);

    localparam int IDX_W  = $clog2(WORD_TABLE_DEPTH);
    localparam int CNT_W  = $clog2(MAX_REPS + 1);
    localparam int SEEN_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int EXT_W  = (IDX_W > kwi_pkg::WORD_W) ? IDX_W : kwi_pkg::WORD_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLEAR  = 5'b00010,
        S_WORD   = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]              r_clr_idx, n_clr_idx;
    logic                          r_pending, n_pending;
    logic                          r_op, r_first, r_last;
    logic [kwi_pkg::LETTER_W-1:0]  r_letter;
    logic [kwi_pkg::ALPHA_W-1:0]   r_alpha;
    logic [kwi_pkg::WLEN_W-1:0]    r_wlen;
    logic [kwi_pkg::WEIGHT_W-1:0]  r_weight;
    logic [kwi_pkg::WORD_W-1:0]    r_word;
    logic [IDX_W-1:0]              r_idx;
    logic [kwi_pkg::POS_OUT_W-1:0] r_pos;
    logic [kwi_pkg::COMMON_W-1:0]  r_common, n_common;
    logic                          r_valid, n_valid;

    logic                          accept;
    logic                          roll_step;
    logic [kwi_pkg::WORD_W-1:0]    roll_word;
    logic                          roll_complete;
    logic [SEEN_W-1:0]             roll_pos;
    logic [EXT_W-1:0]              word_ext;

    kwi_pkg::t_tbl_ctl             tbl_ctl;
    logic [IDX_W-1:0]              tbl_wr_idx;
    logic [CNT_W-1:0]              tbl_wr_cnt;
    logic [CNT_W-1:0]              tbl_cnt;
    logic [kwi_pkg::POS_OUT_W-1:0] tbl_pos;
    logic                          hit;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign roll_step = (r_state == S_WORD);
    assign word_ext  = EXT_W'(roll_word);
    assign hit       = (tbl_cnt != '0);

    kwi_word_roll #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_roll (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (roll_step),
        .i_first    (r_first),
        .i_letter   (r_letter),
        .i_alpha    (r_alpha),
        .i_wlen     (r_wlen),
        .i_weight   (r_weight),
        .o_word     (roll_word),
        .o_complete (roll_complete),
        .o_pos      (roll_pos)
    );

    kwi_hit_table #(
        .WORD_TABLE_DEPTH (WORD_TABLE_DEPTH),
        .MAX_REPS         (MAX_REPS)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_rd_idx  (r_idx),
        .i_wr_idx  (tbl_wr_idx),
        .i_wr_cnt  (tbl_wr_cnt),
        .i_wr_slot (tbl_cnt),
        .i_wr_pos  (r_pos),
        .o_cnt     (tbl_cnt),
        .o_pos     (tbl_pos)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_pending  = r_pending;
        n_common   = r_common;
        n_valid    = 1'b0;
        tbl_ctl    = '0;
        tbl_wr_idx = r_idx;
        tbl_wr_cnt = tbl_cnt + CNT_W'(1);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_first && !i_opcode) begin
                        n_state   = S_CLEAR;
                        n_clr_idx = '0;
                        n_pending = 1'b1;
                    end else begin
                        n_state = S_WORD;
                    end
                end
            end
            S_CLEAR: begin
                tbl_ctl.cnt_we = 1'b1;
                tbl_wr_idx     = r_clr_idx;
                tbl_wr_cnt     = '0;
                n_clr_idx      = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(WORD_TABLE_DEPTH - 1)) begin
                    n_state   = r_pending ? S_WORD : S_IDLE;
                    n_pending = 1'b0;
                end
            end
            S_WORD: begin
                if (r_first && r_op) begin
                    n_common = '0;
                end
                n_state = roll_complete ? S_READ : S_IDLE;
            end
            S_READ: begin
                tbl_ctl.rd = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
                if (r_op) begin
                    if (hit && (r_common != '1)) begin
                        n_common = r_common + kwi_pkg::COMMON_W'(1);
                    end
                    n_valid = 1'b1;
                end else if (tbl_cnt < CNT_W'(MAX_REPS)) begin
                    tbl_ctl.cnt_we = 1'b1;
                    tbl_ctl.pos_we = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_pending <= 1'b0;
            r_common  <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pending <= n_pending;
            r_common  <= n_common;
            r_valid   <= n_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= kwi_pkg::ALPHA_RESET;
            r_wlen   <= kwi_pkg::WLEN_RESET;
            r_weight <= kwi_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (kwi_pkg::t_cfg_idx'(i_cfg_idx))
                kwi_pkg::CFG_ALPHA_SIZE:        r_alpha  <= i_cfg_wdata[kwi_pkg::ALPHA_W-1:0];
                kwi_pkg::CFG_WORD_LENGTH:       r_wlen   <= i_cfg_wdata[kwi_pkg::WLEN_W-1:0];
                kwi_pkg::CFG_HIGH_PLACE_WEIGHT: r_weight <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // transaction payload and per-word registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_letter <= i_letter;
            r_first  <= i_first;
            r_last   <= i_last;
        end
        if (r_state == S_WORD) begin
            r_word <= roll_word;
            r_idx  <= word_ext[IDX_W-1:0];
            r_pos  <= kwi_pkg::POS_OUT_W'(roll_pos);
        end
        if (n_valid) begin
            o_word         <= r_word;
            o_a_hits       <= kwi_pkg::HITS_W'(tbl_cnt);
            o_a_first_pos  <= hit ? tbl_pos : '0;
            o_common_count <= n_common;
            o_end_of_seq   <= r_last;
        end
    end

    assign o_valid = r_valid;

endmodule

/* rtl/kwi_word_roll.sv */
module kwi_word_roll #(
    parameter int MAX_SEQ_LEN = kwi_pkg::MAX_SEQ_LEN,
    localparam int SEEN_W = $clog2(MAX_SEQ_LEN + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_first,
    input  logic [kwi_pkg::LETTER_W-1:0]  i_letter,
    input  logic [kwi_pkg::ALPHA_W-1:0]   i_alpha,
    input  logic [kwi_pkg::WLEN_W-1:0]    i_wlen,
    input  logic [kwi_pkg::WEIGHT_W-1:0]  i_weight,
    output logic [kwi_pkg::WORD_W-1:0]    o_word,
    output logic                          o_complete,
    output logic [SEEN_W-1:0]             o_pos
);

    localparam int PROD_W = kwi_pkg::WORD_W + kwi_pkg::ALPHA_W;

    logic [kwi_pkg::WORD_W-1:0]   r_word;
    logic [SEEN_W-1:0]            r_seen;
    logic [kwi_pkg::LETTER_W-1:0] r_hist [kwi_pkg::HIST_DEPTH];

    logic [kwi_pkg::WLEN_W-1:0]   k;
    logic [kwi_pkg::HIST_IW-1:0]  km1;
    logic [kwi_pkg::LETTER_W-1:0] lt;
    logic [kwi_pkg::WORD_W-1:0]   base_word;
    logic [SEEN_W-1:0]            base_seen;
    logic [kwi_pkg::LETTER_W-1:0] n_hist [kwi_pkg::HIST_DEPTH];
    logic [PROD_W-1:0]            grow;
    logic [PROD_W-1:0]            drop;
    logic [kwi_pkg::WORD_W-1:0]   w;
    logic [kwi_pkg::WORD_W-1:0]   n_word;
    logic [SEEN_W:0]              seen_inc;
    logic [SEEN_W-1:0]            n_seen;
    logic [SEEN_W-1:0]            diff;

    always_comb begin
        if (i_wlen == '0) begin
            k = kwi_pkg::WLEN_W'(1);
        end else if (i_wlen > kwi_pkg::WLEN_W'(kwi_pkg::HIST_DEPTH)) begin
            k = kwi_pkg::WLEN_W'(kwi_pkg::HIST_DEPTH);
        end else begin
            k = i_wlen;
        end
        km1 = kwi_pkg::HIST_IW'(k - kwi_pkg::WLEN_W'(1));

        lt = (i_letter >= i_alpha) ? '0 : i_letter;

        // a first letter starts from a cleared word
        base_word = i_first ? '0 : r_word;
        base_seen = i_first ? '0 : r_seen;
        n_hist[0] = lt;
        for (int i = 1; i < kwi_pkg::HIST_DEPTH; i++) begin
            n_hist[i] = i_first ? '0 : r_hist[i-1];
        end

        grow = PROD_W'(base_word) * PROD_W'(i_alpha);
        w    = kwi_pkg::WORD_W'(grow + PROD_W'(lt));
        drop = PROD_W'(n_hist[km1]) * PROD_W'(i_weight);
        n_word = w - kwi_pkg::WORD_W'(drop);

        o_complete = base_seen >= SEEN_W'(km1);

        seen_inc = (SEEN_W + 1)'(base_seen) + (SEEN_W + 1)'(1);
        n_seen   = (seen_inc >= (SEEN_W + 1)'(MAX_SEQ_LEN)) ? SEEN_W'(MAX_SEQ_LEN)
                                                           : SEEN_W'(seen_inc);

        diff  = base_seen - SEEN_W'(km1);
        o_pos = (diff > SEEN_W'(MAX_SEQ_LEN - 1)) ? SEEN_W'(MAX_SEQ_LEN - 1) : diff;
        o_word = w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_seen <= '0;
            for (int i = 0; i < kwi_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_step) begin
            r_word <= o_complete ? n_word : w;
            r_seen <= n_seen;
            for (int i = 0; i < kwi_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= n_hist[i];
            end
        end
    end

endmodule

/* rtl/kwi_hit_table.sv */
module kwi_hit_table #(
    parameter int WORD_TABLE_DEPTH = kwi_pkg::WORD_TABLE_DEPTH,
    parameter int MAX_REPS         = kwi_pkg::MAX_REPS,
    localparam int IDX_W  = $clog2(WORD_TABLE_DEPTH),
    localparam int CNT_W  = $clog2(MAX_REPS + 1)
) (
    input  logic                           i_clk,
    input  kwi_pkg::t_tbl_ctl              i_ctl,
    input  logic [IDX_W-1:0]               i_rd_idx,
    input  logic [IDX_W-1:0]               i_wr_idx,
    input  logic [CNT_W-1:0]               i_wr_cnt,
    input  logic [CNT_W-1:0]               i_wr_slot,
    input  logic [kwi_pkg::POS_OUT_W-1:0]  i_wr_pos,
    output logic [CNT_W-1:0]               o_cnt,
    output logic [kwi_pkg::POS_OUT_W-1:0]  o_pos
);

    localparam int POS_DEPTH = WORD_TABLE_DEPTH * MAX_REPS;
    localparam int POS_AW    = $clog2(POS_DEPTH);

    logic [CNT_W-1:0]              r_cnt_mem [WORD_TABLE_DEPTH];
    logic [kwi_pkg::POS_OUT_W-1:0] r_pos_mem [POS_DEPTH];

    logic [POS_AW-1:0] rd_pos_addr;
    logic [POS_AW-1:0] wr_pos_addr;

    // positions of one word sit in a row of MAX_REPS entries
    assign rd_pos_addr = POS_AW'(i_rd_idx) * POS_AW'(MAX_REPS);
    assign wr_pos_addr = POS_AW'(i_wr_idx) * POS_AW'(MAX_REPS) + POS_AW'(i_wr_slot);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cnt_we) begin
            r_cnt_mem[i_wr_idx] <= i_wr_cnt;
        end
        if (i_ctl.rd) begin
            o_cnt <= r_cnt_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pos_we) begin
            r_pos_mem[wr_pos_addr] <= i_wr_pos;
        end
        if (i_ctl.rd) begin
            o_pos <= r_pos_mem[rd_pos_addr];
        end
    end

endmodule

/* rtl/kwi_checker.sv */
module kwi_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_valid,
    input logic [kwi_pkg::HITS_W-1:0]     o_a_hits,
    input logic [kwi_pkg::POS_OUT_W-1:0]  o_a_first_pos
);

    // the hit-count sweep holds the block busy right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_a_hits == '0)) |-> (o_a_first_pos == '0))
        else $error("first position not zero on a missed word");

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !busy) |-> $past(busy))
        else $error("result strobe without a transaction in flight");

endmodule

bind kmer_word_index_and_match_core kwi_checker u_kwi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_a_hits      (o_a_hits),
    .o_a_first_pos (o_a_first_pos)
);

/* dv/kmer_word_index_and_match_checker.sv */
module kmer_word_index_and_match_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_opcode,
    input  logic [kwi_pkg::LETTER_W-1:0]   i_letter,
    input  logic                           i_first,
    input  logic                           i_last,
    input  logic                           i_cfg_we,
    input  logic [kwi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kwi_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    input  logic [kwi_pkg::WORD_W-1:0]     i_word,
    input  logic [kwi_pkg::HITS_W-1:0]     i_a_hits,
    input  logic [kwi_pkg::POS_OUT_W-1:0]  i_a_first_pos,
    input  logic [kwi_pkg::COMMON_W-1:0]   i_common_count,
    input  logic                           i_end_of_seq,
    output int                             o_fail_count,
    output int                             o_pending
);
    import kwi_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]    word;
        logic [HITS_W-1:0]    hits;
        logic [POS_OUT_W-1:0] first_pos;
        logic [COMMON_W-1:0]  common;
        logic                 end_of_seq;
    } t_lookup;

    logic [ALPHA_W-1:0]   alpha_q;
    logic [WLEN_W-1:0]    wlen_q;
    logic [WEIGHT_W-1:0]  weight_q;
    logic [WORD_W-1:0]    roll_q;
    logic [LETTER_W-1:0]  hist_q [HIST_DEPTH];
    int unsigned          seen_q;
    int unsigned          hit_count [int unsigned];
    logic [15:0]          a_pos [int unsigned];
    logic [COMMON_W-1:0]  common_q;
    t_lookup              expected_lookups [$];
    int                   fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one accepted letter: index an A word or look up a B word
    task automatic index_or_lookup_letter(input logic is_b, input logic [LETTER_W-1:0] raw,
                                          input logic first, input logic last);
        int unsigned          k;
        int unsigned          prev_seen;
        int unsigned          idx;
        int unsigned          n;
        int unsigned          pos;
        logic [LETTER_W-1:0]  code;
        logic [31:0]          acc;
        logic [WORD_W-1:0]    w;
        t_lookup              res;
        k = (wlen_q == 0) ? 1 : ((wlen_q > HIST_DEPTH) ? HIST_DEPTH : wlen_q);
        code = (raw >= alpha_q) ? '0 : raw;
        if (first) begin
            roll_q = '0;
            seen_q = 0;
            foreach (hist_q[i]) hist_q[i] = '0;
            if (is_b) common_q = '0;
            else hit_count.delete();
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
        hist_q[0] = code;
        prev_seen = seen_q;
        seen_q = (prev_seen + 1 >= MAX_SEQ_LEN) ? MAX_SEQ_LEN : prev_seen + 1;
        acc = roll_q * alpha_q + code;
        w = acc[15:0];
        if (prev_seen < k - 1) begin
            roll_q = w;
            return;
        end
        // drop the oldest letter of the word just taken
        acc = w - hist_q[k-1] * weight_q;
        roll_q = acc[15:0];
        idx = w % WORD_TABLE_DEPTH;
        n = hit_count.exists(idx) ? hit_count[idx] : 0;
        if (!is_b) begin
            pos = prev_seen - (k - 1);
            if (pos > MAX_SEQ_LEN - 1) pos = MAX_SEQ_LEN - 1;
            if (n < MAX_REPS) begin
                a_pos[idx * MAX_REPS + n] = pos[15:0];
                hit_count[idx] = n + 1;
            end
            return;
        end
        if (n > 0 && common_q != '1) common_q++;
        res.word       = w;
        res.hits       = n[HITS_W-1:0];
        res.first_pos  = (n > 0) ? a_pos[idx * MAX_REPS] : '0;
        res.common     = common_q;
        res.end_of_seq = last;
        expected_lookups.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (!i_rst_n) begin
            alpha_q  = ALPHA_RESET;
            wlen_q   = WLEN_RESET;
            weight_q = WEIGHT_RESET;
            roll_q   = '0;
            seen_q   = 0;
            foreach (hist_q[i]) hist_q[i] = '0;
            hit_count.delete();
            a_pos.delete();
            common_q = '0;
            expected_lookups.delete();
        end else begin
            if (i_valid) begin
                if (expected_lookups.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual word %0h",
                             $time, i_word);
                end else begin
                    exp_r = expected_lookups.pop_front();
                    compare_field("word", exp_r.word, i_word);
                    compare_field("a_hits", exp_r.hits, i_a_hits);
                    compare_field("a_first_pos", exp_r.first_pos, i_a_first_pos);
                    compare_field("common_count", exp_r.common, i_common_count);
                    compare_field("end_of_seq", exp_r.end_of_seq, i_end_of_seq);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ALPHA_SIZE:        alpha_q  = i_cfg_wdata[ALPHA_W-1:0];
                    CFG_WORD_LENGTH:       wlen_q   = i_cfg_wdata[WLEN_W-1:0];
                    CFG_HIGH_PLACE_WEIGHT: weight_q = i_cfg_wdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                index_or_lookup_letter(i_opcode, i_letter, i_first, i_last);
        end
        o_pending    <= expected_lookups.size();
        o_fail_count <= fails;
    end

endmodule

/* dv/tb_kmer_word_index_and_match_core.sv */
module tb_kmer_word_index_and_match_core;
    import kwi_pkg::*;

    localparam int  CLK_HALF  = 10;
    localparam int  RUN_LIMIT = 80_000_000;
    localparam logic OP_A     = 1'b0;
    localparam logic OP_B     = 1'b1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  i_opcode    = 1'b0;
    logic [LETTER_W-1:0]   i_letter    = '0;
    logic                  i_first     = 1'b0;
    logic                  i_last      = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    logic                  busy;
    logic                  o_valid;
    logic [WORD_W-1:0]     o_word;
    logic [HITS_W-1:0]     o_a_hits;
    logic [POS_OUT_W-1:0]  o_a_first_pos;
    logic [COMMON_W-1:0]   o_common_count;
    logic                  o_end_of_seq;

    int                    fail_count;
    int                    pending;
    bit                    calm = 1'b0;
    int                    letters_sent = 0;
    logic [LETTER_W-1:0]   a_letters [$];

    always #(CLK_HALF) i_clk = ~i_clk;

    kmer_word_index_and_match_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_letter       (i_letter),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_word         (o_word),
        .o_a_hits       (o_a_hits),
        .o_a_first_pos  (o_a_first_pos),
        .o_common_count (o_common_count),
        .o_end_of_seq   (o_end_of_seq)
    );

    kmer_word_index_and_match_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_letter       (i_letter),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (o_valid),
        .i_word         (o_word),
        .i_a_hits       (o_a_hits),
        .i_a_first_pos  (o_a_first_pos),
        .i_common_count (o_common_count),
        .i_end_of_seq   (o_end_of_seq),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LETTER_W-1:0] rand_letter(input int alpha);
        if (alpha > 0 && $urandom_range(0, 99) < 85)
            return LETTER_W'($urandom_range(0, alpha - 1));
        return LETTER_W'($urandom_range(0, 31));
    endfunction

    task automatic send_letter(input logic op, input logic [LETTER_W-1:0] code,
                               input logic first, input logic last);
        int gap;
        start    <= 1'b1;
        i_opcode <= op;
        i_letter <= code;
        i_first  <= first;
        i_last   <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        letters_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // registers change only once the core has drained and gone idle
    task automatic settle_and_configure(input int alpha, input int wlen, input int weight);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ALPHA_SIZE;
        i_cfg_wdata <= CFG_W'(alpha);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WORD_LENGTH;
        i_cfg_wdata <= CFG_W'(wlen);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_HIGH_PLACE_WEIGHT;
        i_cfg_wdata <= CFG_W'(weight);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one A sequence builds the index, then mostly B sequences drawn from it
    task automatic run_phase(input int alpha, input int wlen, input int weight, input int quota);
        int                   len;
        int                   off;
        int                   r;
        int                   stop;
        logic [LETTER_W-1:0]  c;
        settle_and_configure(alpha, wlen, weight);
        a_letters.delete();
        calm = ($urandom_range(0, 3) == 0);
        len = $urandom_range(10, 80);
        for (int i = 0; i < len; i++) begin
            c = rand_letter(alpha);
            a_letters.push_back(c);
            send_letter(OP_A, c, i == 0, i == len - 1);
        end
        stop = letters_sent + quota - len;
        while (letters_sent < stop) begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            len = $urandom_range(1, 24);
            if (r < 65) begin
                off = $urandom_range(0, a_letters.size() - 1);
                for (int i = 0; i < len; i++) begin
                    c = a_letters[(off + i) % a_letters.size()];
                    if ($urandom_range(0, 9) == 0) c = rand_letter(alpha);
                    send_letter(OP_B, c, i == 0 && $urandom_range(0, 9) != 0, i == len - 1);
                end
            end else if (r < 82) begin
                for (int i = 0; i < len; i++)
                    send_letter(OP_B, rand_letter(alpha), i == 0, i == len - 1);
            end else if (r < 90) begin
                // extend the index without a new first
                for (int i = 0; i < len / 3 + 1; i++) begin
                    c = rand_letter(alpha);
                    a_letters.push_back(c);
                    send_letter(OP_A, c, 1'b0, $urandom_range(0, 7) == 0);
                end
            end else begin
                r = $urandom_range(0, 1);
                send_letter(r[0], LETTER_W'($urandom_range(0, 31)),
                            r[0] & 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: alphabet of 4, words of 8; all-threes gives the top word
        send_letter(OP_A, 5'd3, 1'b1, 1'b0);
        repeat (7) send_letter(OP_A, 5'd3, 1'b0, 1'b0);
        send_letter(OP_A, 5'd31, 1'b0, 1'b0);
        send_letter(OP_A, 5'd0, 1'b0, 1'b0);
        send_letter(OP_A, 5'd1, 1'b0, 1'b0);
        send_letter(OP_A, 5'd2, 1'b0, 1'b1);
        // last before the word is complete gives nothing
        send_letter(OP_B, 5'd3, 1'b1, 1'b0);
        repeat (5) send_letter(OP_B, 5'd3, 1'b0, 1'b0);
        send_letter(OP_B, 5'd3, 1'b0, 1'b1);
        send_letter(OP_B, 5'd3, 1'b0, 1'b0);
        send_letter(OP_B, 5'd31, 1'b0, 1'b0);
        send_letter(OP_B, 5'd17, 1'b0, 1'b0);
        // opcode flips with no first: the rolling word carries on
        send_letter(OP_A, 5'd1, 1'b0, 1'b0);
        send_letter(OP_B, 5'd2, 1'b0, 1'b1);

        run_phase(2, 1, 1, 170);
        run_phase(20, 8, 16384, 170);
        run_phase(2, 8, 128, 170);
        run_phase(4, 3, 16, 170);
        run_phase(5, 0, 1, 170);
        run_phase(3, 15, 2187, 170);
        run_phase(20, 2, 20, 170);
        run_phase(31, 4, 16'hFFFF, 170);
        run_phase(4, 8, 16384, 170);

        start <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < 10000 && pending != 0; n++) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/kwi_pkg.sv
rtl/kwi_word_roll.sv
rtl/kwi_hit_table.sv
rtl/kmer_word_index_and_match_core.sv
rtl/kwi_checker.sv
dv/kmer_word_index_and_match_checker.sv
dv/tb_kmer_word_index_and_match_core.sv
